### hdl/mbbn_pkg.sv
package mbbn_pkg;

  // default coordinate format: signed Q16.16 in 32 bits
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // entries held between the front and back ends
  localparam int QUEUE_DEPTH = 2;

  // queue entry: {zero, scale, neg[2:0], mag[2], mag[1], mag[0]}
  function automatic int ent_width(input int cw);
    return 4 * cw + 4;
  endfunction

endpackage

### hdl/mbbn_queue.sv
module mbbn_queue
  import mbbn_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CTW-1:0]   cnt_r;

  assign full  = (cnt_r == CTW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### hdl/mbbn_front.sv
module mbbn_front
  import mbbn_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int ENT_W      = ent_width(COORD_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic                          in_first,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          q_push,
  output logic [ENT_W-1:0]              q_wdata,
  input  logic                          q_full
);

  localparam int CW    = COORD_WIDTH;
  localparam int QW    = 2 * FRAC_BITS + 1;
  localparam int CNT_W = $clog2(QW);
  localparam int DW    = (QW > CW) ? QW : CW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                 st_r, st_nxt;
  logic signed [CW-1:0] min_r [3], min_nxt [3];
  logic signed [CW-1:0] max_r [3], max_nxt [3];
  logic signed [CW-1:0] ctr_r [3], ctr_nxt [3];
  logic [CW-1:0]        scale_r, scale_nxt;
  logic                 rdy_r, rdy_nxt;
  logic                 zero_r, zero_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [QW-1:0]        quo_r, quo_nxt;
  logic [CW-1:0]        dvs_r, dvs_nxt;

  logic signed [CW-1:0] vin [3];
  logic signed [CW:0]   sum [3];
  logic signed [CW:0]   ext [3];
  logic [CW-1:0]        extu [3];
  logic signed [CW-1:0] cent [3];
  logic [CW-1:0]        ext01, largest;
  logic signed [CW:0]   dif [3];
  logic signed [CW:0]   absd [3];
  logic [CW-1:0]        mag [3];
  logic [2:0]           neg;
  logic                 acc, start;

  logic                 nb, ge;
  logic [CW:0]          rem_sh, trial;
  logic [CW-1:0]        rem_step;
  logic [QW-1:0]        quo_step;
  logic [DW-1:0]        quo_ext;
  logic [CW-1:0]        scale_fin;

  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;

  // handshake: measure always taken when idle, normalize needs scale and room
  assign in_ready = (st_r == ST_IDLE) && (!in_func || (rdy_r && !q_full));
  assign acc      = in_valid && in_ready;
  assign start    = (st_r == ST_IDLE) && in_valid && in_func && !rdy_r;

  // box center and extents from the current bounds
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a]  = {min_r[a][CW-1], min_r[a]} + {max_r[a][CW-1], max_r[a]};
      ext[a]  = {max_r[a][CW-1], max_r[a]} - {min_r[a][CW-1], min_r[a]};
      extu[a] = ext[a][CW-1:0];
      cent[a] = sum[a][CW:1];
    end
    ext01   = (extu[0] > extu[1]) ? extu[0] : extu[1];
    largest = (ext01 > extu[2]) ? ext01 : extu[2];
  end

  // offset from center, as sign and magnitude
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dif[a]  = {vin[a][CW-1], vin[a]} - {ctr_r[a][CW-1], ctr_r[a]};
      neg[a]  = dif[a][CW];
      absd[a] = neg[a] ? -dif[a] : dif[a];
      mag[a]  = absd[a][CW-1:0];
    end
  end

  assign q_push  = acc && in_func;
  assign q_wdata = {zero_r, scale_r, neg[2], neg[1], neg[0], mag[2], mag[1], mag[0]};

  // restoring divide of 2^(2*FRAC_BITS) by the largest extent, one bit a cycle
  assign nb       = (cnt_r == CNT_W'(QW - 1));
  assign rem_sh   = {rem_r, nb};
  assign trial    = rem_sh - {1'b0, dvs_r};
  assign ge       = (rem_sh >= {1'b0, dvs_r});
  assign rem_step = ge ? trial[CW-1:0] : rem_sh[CW-1:0];
  assign quo_step = {quo_r[QW-2:0], ge};
  assign quo_ext  = DW'(quo_step);
  assign scale_fin = (quo_ext > DW'({CW{1'b1}})) ? {CW{1'b1}} : quo_ext[CW-1:0];

  // next state
  always_comb begin
    st_nxt    = st_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    ctr_nxt   = ctr_r;
    scale_nxt = scale_r;
    rdy_nxt   = rdy_r;
    zero_nxt  = zero_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    unique case (st_r)
      ST_IDLE: begin
        // measure vertex: widen or restart bounds
        if (acc && !in_func) begin
          for (int a = 0; a < 3; a++) begin
            if (in_first || (vin[a] < min_r[a])) begin
              min_nxt[a] = vin[a];
            end
            if (in_first || (vin[a] > max_r[a])) begin
              max_nxt[a] = vin[a];
            end
          end
          rdy_nxt = 1'b0;
        end
        // first normalize vertex after a measure: set up center and scale
        if (start) begin
          ctr_nxt = cent;
          dvs_nxt = largest;
          rem_nxt = '0;
          cnt_nxt = CNT_W'(QW - 1);
          if (largest == '0) begin
            zero_nxt  = 1'b1;
            scale_nxt = '0;
            rdy_nxt   = 1'b1;
          end else begin
            st_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        if (cnt_r == '0) begin
          scale_nxt = scale_fin;
          zero_nxt  = 1'b0;
          rdy_nxt   = 1'b1;
          st_nxt    = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control and mesh state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      min_r   <= '{default: '0};
      max_r   <= '{default: '0};
      ctr_r   <= '{default: '0};
      scale_r <= '0;
      rdy_r   <= 1'b0;
      zero_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      ctr_r   <= ctr_nxt;
      scale_r <= scale_nxt;
      rdy_r   <= rdy_nxt;
      zero_r  <= zero_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  // a divide only runs while the scale is stale
  a_div_stale: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (!rdy_r && !in_ready))
    else $error("divider running with a valid scale");

  // a normalize request only goes out on a fresh scale and free queue
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (rdy_r && !q_full && !start))
    else $error("queue push without scale or room");

endmodule

### hdl/mbbn_back.sv
module mbbn_back
  import mbbn_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int ENT_W      = ent_width(COORD_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  logic [ENT_W-1:0]            q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS:0]   out_x,
  output logic signed [FRAC_BITS:0]   out_y,
  output logic signed [FRAC_BITS:0]   out_z,
  output logic                        out_degenerate
);

  localparam int CW   = COORD_WIDTH;
  localparam int PW   = 2 * CW;
  localparam int PQ_W = PW - FRAC_BITS;

  localparam logic [PQ_W-1:0] HALF_Q = PQ_W'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0] HALF_U = {2'b01, {(FRAC_BITS - 1){1'b0}}};
  localparam logic signed [FRAC_BITS:0] POS_HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};
  localparam logic signed [FRAC_BITS:0] NEG_HALF = {2'b11, {(FRAC_BITS - 1){1'b0}}};

  logic [CW-1:0] mag [3];
  logic [2:0]    neg;
  logic [CW-1:0] scale;
  logic          zero;
  logic [CW-1:0] mag_sel;
  logic [PW-1:0] prod;
  logic          step, last, out_load;

  logic [1:0]                cnt_r;
  logic [PW-1:0]             prod_r [3];
  logic [2:0]                pd_neg_r;
  logic                      pd_zero_r;
  logic                      pd_vld_r;
  logic                      out_valid_r;
  logic signed [FRAC_BITS:0] out_x_r, out_y_r, out_z_r;
  logic                      out_deg_r;

  // scale the product back and clamp at one half, then restore the sign
  function automatic logic [FRAC_BITS:0] norm_axis(input logic [PW-1:0] p, input logic ng);
    logic [PQ_W-1:0]    q;
    logic [FRAC_BITS:0] m;
    q = p[PW-1:FRAC_BITS];
    m = (q > HALF_Q) ? HALF_U : q[FRAC_BITS:0];
    return ng ? -m : m;
  endfunction

  // queue entry fields
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = q_rdata[a*CW +: CW];
    end
  end
  assign neg   = q_rdata[3*CW +: 3];
  assign scale = q_rdata[3*CW+3 +: CW];
  assign zero  = q_rdata[4*CW+3];

  // one shared multiplier, one axis a cycle while the queue holds an entry and the hold stage can take it
  always_comb begin
    unique case (cnt_r)
      2'd0:    mag_sel = mag[0];
      2'd1:    mag_sel = mag[1];
      2'd2:    mag_sel = mag[2];
      default: mag_sel = '0;
    endcase
  end
  assign prod = PW'(mag_sel) * PW'(scale);

  assign out_load = pd_vld_r && (!out_valid_r || out_ready);
  assign step     = !q_empty && (!pd_vld_r || out_load);
  assign last     = step && (cnt_r == 2'd2);
  assign q_pop    = last;

  // axis counter and product hold stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      pd_vld_r <= 1'b0;
    end else begin
      if (step) begin
        cnt_r <= last ? 2'd0 : cnt_r + 1'b1;
      end
      if (last) begin
        pd_vld_r <= 1'b1;
      end else if (out_load) begin
        pd_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (step && (cnt_r == 2'(a))) begin
        prod_r[a] <= prod;
      end
    end
    if (last) begin
      pd_neg_r  <= neg;
      pd_zero_r <= zero;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r   <= pd_zero_r ? '0 : norm_axis(prod_r[0], pd_neg_r[0]);
      out_y_r   <= pd_zero_r ? '0 : norm_axis(prod_r[1], pd_neg_r[1]);
      out_z_r   <= pd_zero_r ? '0 : norm_axis(prod_r[2], pd_neg_r[2]);
      out_deg_r <= pd_zero_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_z          = out_z_r;
  assign out_degenerate = out_deg_r;

  // entries leave the queue only after their third axis
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (cnt_r == 2'd2 && !q_empty))
    else $error("queue pop before all axes multiplied");

  // a degenerate mesh gives an all-zero vertex
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_deg_r) |-> (out_x_r == '0 && out_y_r == '0 && out_z_r == '0))
    else $error("degenerate result with nonzero coordinate");

  // results stay within plus or minus one half
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_x_r <= POS_HALF && out_x_r >= NEG_HALF &&
                     out_y_r <= POS_HALF && out_y_r >= NEG_HALF &&
                     out_z_r <= POS_HALF && out_z_r >= NEG_HALF))
    else $error("normalized coordinate beyond one half");

endmodule

### hdl/mesh_bounding_box_normalize.sv
// Measure vertices give no result; they are taken whenever the front end is idle.
// Normalize vertices share a single multiplier across the three axes, and new ones are
// taken while earlier ones still wait in the queue.
// The first normalize vertex after reset or any measure vertex waits while a bit-serial
// divider forms the reciprocal scale, 2^(2*FRAC_BITS) over the largest extent (2^32 at Q16.16).
// rst_n is synchronous, active low; it clears bounds, center, scale and all control.
module mesh_bounding_box_normalize
  import mbbn_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic                          in_first,
  input  logic signed [COORD_WIDTH-1:0] in_x_in,
  input  logic signed [COORD_WIDTH-1:0] in_y_in,
  input  logic signed [COORD_WIDTH-1:0] in_z_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [FRAC_BITS:0]     out_x_out,
  output logic signed [FRAC_BITS:0]     out_y_out,
  output logic signed [FRAC_BITS:0]     out_z_out,
  output logic                          out_degenerate
);

  localparam int ENT_W = ent_width(COORD_WIDTH);

  logic             q_push, q_pop, q_full, q_empty;
  logic [ENT_W-1:0] q_wdata, q_rdata;

  // bounds tracking, center and reciprocal setup
  mbbn_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .in_first (in_first),
    .in_x     (in_x_in),
    .in_y     (in_y_in),
    .in_z     (in_z_in),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  // normalize requests in flight
  mbbn_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // scaling multiply, clamp and output register
  mbbn_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x_out),
    .out_y          (out_y_out),
    .out_z          (out_z_out),
    .out_degenerate (out_degenerate)
  );

endmodule
